@@ sv/i2c_master_reg16_transfer_top_macros.svh @@
// Assertion helpers for the I2C register transfer block.
`ifndef I2C_MASTER_REG16_TRANSFER_TOP_MACROS_SVH
`define I2C_MASTER_REG16_TRANSFER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define I2CM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/i2cm_pkg.sv @@
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [9:0] HALF_PERIOD_RST = 10'd80;
  localparam logic [9:0] ACK_TIMEOUT_RST = 10'd250;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_TXA, PH_TXB, PH_AK1, PH_AK2, PH_POLL,
    PH_RXA, PH_RXB, PH_K1, PH_K2, PH_K3, PH_K4, PH_SP1, PH_SP2, PH_SP3, PH_FIN
  } phase_t;

  typedef enum logic [2:0] {
    STG_ADDR_W, STG_REG_HI, STG_REG_LO, STG_ADDR_R, STG_DATA
  } stage_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_res_t;

endpackage

@@ sv/i2c_master_reg16_transfer_top.sv @@
`timescale 1ns / 1ps
// I2C master for devices with a sixteen-bit register address.
// Input channel (in_valid/in_stall): one transaction per system clock unless
// stalled. kind selects start transfer, load a write-buffer byte, or one
// elapsed clock tick; ticks advance the line sequencer, which drives SCL and
// open-drain SDA. Result channel (out_valid/out_stall): exactly one
// transaction per input, in order, carrying line drives, received byte,
// busy, done and status. Each result is registered and shown once earlier
// results are taken. The write buffer is a synchronous RAM;
// the byte an acknowledge will need is prefetched ahead of use, with
// same-cycle loads forwarded, so the single read port never stalls a tick.
// A two-entry output skid lets inputs keep flowing while the receiver
// stalls; in_stall rises only once both entries hold unread results.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 half period,
// index 1 ACK timeout; write only while idle.
// Reset: lines released high, sequencer idle, registers at 80 and 250, no
// results pending. Buffer contents are undefined until loaded.
module i2c_master_reg16_transfer_top #(
  parameter int MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_kind,
  input  logic [6:0]                      in_dev_address,
  input  logic [15:0]                     in_reg_address,
  input  logic                            in_is_read,
  input  logic [5:0]                      in_xfer_length,
  input  logic [4:0]                      in_buf_index,
  input  logic [7:0]                      in_write_byte,
  input  logic                            in_sda_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_scl_level,
  output logic                            out_sda_release,
  output logic [7:0]                      out_rx_byte,
  output logic                            out_rx_valid,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic [1:0]                      out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic               acc;
  logic               full;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [7:0]         mem_wr_data;
  logic [AW-1:0]      mem_rd_addr;
  logic [7:0]         mem_rd_data;
  i2cm_pkg::out_res_t res;
  i2cm_pkg::out_res_t out_res;

  // hold off inputs only when the skid has no free entry
  assign in_stall  = full;
  assign acc       = in_valid && !full;
  assign cfg_ready = 1'b1;

  i2cm_buf_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  i2cm_ctrl #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .kind        (in_kind),
    .dev_address (in_dev_address),
    .reg_address (in_reg_address),
    .is_read     (in_is_read),
    .xfer_length (in_xfer_length),
    .buf_index   (in_buf_index),
    .write_byte  (in_write_byte),
    .sda_sample  (in_sda_sample),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res         (res)
  );

  i2cm_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_scl_level   = out_res.scl_level;
  assign out_sda_release = out_res.sda_release;
  assign out_rx_byte     = out_res.rx_byte;
  assign out_rx_valid    = out_res.rx_valid;
  assign out_busy_res    = out_res.busy_res;
  assign out_done_res    = out_res.done_res;
  assign out_status      = out_res.status;

endmodule

@@ sv/i2cm_buf_mem.sv @@
`timescale 1ns / 1ps
module i2cm_buf_mem #(
  parameter int DEPTH = i2cm_pkg::MAX_LEN_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // forward a same-cycle write so the prefetched byte is never stale
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/i2cm_out_skid.sv @@
`timescale 1ns / 1ps
`include "i2c_master_reg16_transfer_top_macros.svh"
module i2cm_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cm_pkg::out_res_t push_res,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output i2cm_pkg::out_res_t out_res
);

  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  i2cm_pkg::out_res_t main_r, main_nxt;
  i2cm_pkg::out_res_t skid_r, skid_nxt;
  logic               take;

  assign take = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (push) begin
      if (!main_v_r || take) begin
        main_nxt   = push_res;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_res;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  `I2CM_ASSERT_SAME(a_skid_behind_main, clk, rst_n, skid_v_r, main_v_r, "skid holds data with empty head")

endmodule

@@ sv/i2cm_ctrl.sv @@
`timescale 1ns / 1ps
`include "i2c_master_reg16_transfer_top_macros.svh"
module i2cm_ctrl #(
  parameter int MAX_LEN = i2cm_pkg::MAX_LEN_DEF,
  parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic [1:0]                       kind,
  input  logic [6:0]                       dev_address,
  input  logic [15:0]                      reg_address,
  input  logic                             is_read,
  input  logic [i2cm_pkg::LEN_W-1:0]       xfer_length,
  input  logic [4:0]                       buf_index,
  input  logic [7:0]                       write_byte,
  input  logic                             sda_sample,
  input  logic                             cfg_wr,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             mem_wr_en,
  output logic [AW-1:0]                    mem_wr_addr,
  output logic [7:0]                       mem_wr_data,
  output logic [AW-1:0]                    mem_rd_addr,
  input  logic [7:0]                       mem_rd_data,
  output i2cm_pkg::out_res_t               res
);

  localparam int LW = i2cm_pkg::LEN_W;

  logic [9:0] half_r, ackto_r;

  i2cm_pkg::phase_t phase_r, phase_nxt;
  i2cm_pkg::stage_t stage_r, stage_nxt;
  logic [9:0]    delay_r, delay_nxt;
  logic [9:0]    ackw_r, ackw_nxt;
  logic [3:0]    bitc_r, bitc_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [LW-1:0] bytec_r, bytec_nxt;
  logic [6:0]    dev_r, dev_nxt;
  logic [15:0]   reg_r, reg_nxt;
  logic          read_r, read_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          failed_r, failed_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;

  logic [9:0]    hold_val;
  logic          is_start, is_tick, tick_act, zero_read;
  logic [LW-1:0] len_sat;
  logic [LW:0]   bytec_inc;
  logic          more_bytes;
  logic [LW:0]   rd_idx;

  assign hold_val   = (half_r == 10'd0) ? 10'd0 : half_r - 10'd1;
  assign is_start   = acc && (kind == i2cm_pkg::KIND_START) && (phase_r == i2cm_pkg::PH_IDLE);
  assign is_tick    = acc && (kind == i2cm_pkg::KIND_TICK) && (phase_r != i2cm_pkg::PH_IDLE);
  assign tick_act   = is_tick && (delay_r == 10'd0);
  assign len_sat    = (32'(xfer_length) > MAX_LEN) ? LW'(MAX_LEN) : xfer_length;
  assign zero_read  = is_read && (len_sat == '0);
  assign bytec_inc  = {1'b0, bytec_r} + {{LW{1'b0}}, 1'b1};
  assign more_bytes = bytec_inc < {1'b0, len_r};

  // prefetch the byte the next acknowledge will need
  assign rd_idx      = (stage_r == i2cm_pkg::STG_DATA) ? bytec_inc : '0;
  assign mem_rd_addr = AW'(rd_idx);
  assign mem_wr_en   = acc && (kind == i2cm_pkg::KIND_LOAD) && (32'(buf_index) < MAX_LEN);
  assign mem_wr_addr = AW'(buf_index);
  assign mem_wr_data = write_byte;

  always_comb begin
    phase_nxt  = phase_r;
    stage_nxt  = stage_r;
    delay_nxt  = delay_r;
    ackw_nxt   = ackw_r;
    bitc_nxt   = bitc_r;
    shift_nxt  = shift_r;
    bytec_nxt  = bytec_r;
    dev_nxt    = dev_r;
    reg_nxt    = reg_r;
    read_nxt   = read_r;
    len_nxt    = len_r;
    failed_nxt = failed_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    if (is_start) begin
      dev_nxt  = dev_address;
      reg_nxt  = reg_address;
      read_nxt = is_read;
      len_nxt  = len_sat;
      if (!zero_read) begin
        stage_nxt  = i2cm_pkg::STG_ADDR_W;
        failed_nxt = 1'b0;
        bytec_nxt  = '0;
        ackw_nxt   = '0;
        delay_nxt  = '0;
        phase_nxt  = i2cm_pkg::PH_ST1;
      end
    end else if (is_tick && !tick_act) begin
      delay_nxt = delay_r - 10'd1;
    end else if (tick_act) begin
      delay_nxt = hold_val;
      case (phase_r)
        i2cm_pkg::PH_ST1: begin
          sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_ST2;
        end
        i2cm_pkg::PH_ST2: begin
          sda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_ST3;
        end
        i2cm_pkg::PH_ST3: begin
          scl_nxt   = 1'b0;
          shift_nxt = {dev_r, stage_r == i2cm_pkg::STG_ADDR_R};
          bitc_nxt  = '0;
          phase_nxt = i2cm_pkg::PH_TXA;
        end
        i2cm_pkg::PH_TXA: begin
          scl_nxt = 1'b0; sda_nxt = shift_r[7]; phase_nxt = i2cm_pkg::PH_TXB;
        end
        i2cm_pkg::PH_TXB: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], 1'b0};
          bitc_nxt  = bitc_r + 4'd1;
          phase_nxt = (bitc_r >= 4'd7) ? i2cm_pkg::PH_AK1 : i2cm_pkg::PH_TXA;
        end
        i2cm_pkg::PH_AK1: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_AK2;
        end
        i2cm_pkg::PH_AK2: begin
          scl_nxt = 1'b1; ackw_nxt = '0; phase_nxt = i2cm_pkg::PH_POLL;
        end
        i2cm_pkg::PH_POLL: begin
          if (!sda_sample) begin
            scl_nxt = 1'b0;
            case (stage_r)
              i2cm_pkg::STG_ADDR_W: begin
                stage_nxt = i2cm_pkg::STG_REG_HI;
                shift_nxt = reg_r[15:8]; bitc_nxt = '0; phase_nxt = i2cm_pkg::PH_TXA;
              end
              i2cm_pkg::STG_REG_HI: begin
                stage_nxt = i2cm_pkg::STG_REG_LO;
                shift_nxt = reg_r[7:0]; bitc_nxt = '0; phase_nxt = i2cm_pkg::PH_TXA;
              end
              i2cm_pkg::STG_REG_LO: begin
                if (read_r) begin
                  stage_nxt = i2cm_pkg::STG_ADDR_R;
                  phase_nxt = i2cm_pkg::PH_ST1;
                end else begin
                  stage_nxt = i2cm_pkg::STG_DATA;
                  bytec_nxt = '0;
                  if (len_r != '0) begin
                    shift_nxt = mem_rd_data; bitc_nxt = '0; phase_nxt = i2cm_pkg::PH_TXA;
                  end else begin
                    phase_nxt = i2cm_pkg::PH_SP1;
                  end
                end
              end
              i2cm_pkg::STG_ADDR_R: begin
                bytec_nxt = '0; bitc_nxt = '0; shift_nxt = '0;
                phase_nxt = i2cm_pkg::PH_RXA;
              end
              default: begin
                bytec_nxt = bytec_inc[LW-1:0];
                if (more_bytes) begin
                  shift_nxt = mem_rd_data; bitc_nxt = '0; phase_nxt = i2cm_pkg::PH_TXA;
                end else begin
                  phase_nxt = i2cm_pkg::PH_SP1;
                end
              end
            endcase
          end else if (ackw_r >= ackto_r) begin
            // abort: go straight to the SCL-high half of STOP
            failed_nxt = 1'b1;
            sda_nxt    = 1'b0;
            phase_nxt  = i2cm_pkg::PH_SP2;
          end else begin
            ackw_nxt = ackw_r + 10'd1;
          end
        end
        i2cm_pkg::PH_RXA: begin
          sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_RXB;
        end
        i2cm_pkg::PH_RXB: begin
          shift_nxt = {shift_r[6:0], sda_sample};
          scl_nxt   = 1'b0;
          bitc_nxt  = bitc_r + 4'd1;
          phase_nxt = (bitc_r >= 4'd7) ? i2cm_pkg::PH_K1 : i2cm_pkg::PH_RXA;
        end
        i2cm_pkg::PH_K1: begin
          sda_nxt = !more_bytes; phase_nxt = i2cm_pkg::PH_K2;
        end
        i2cm_pkg::PH_K2: begin
          scl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_K3;
        end
        i2cm_pkg::PH_K3, i2cm_pkg::PH_K4: begin
          scl_nxt = 1'b0;
          if (phase_r == i2cm_pkg::PH_K4) begin
            sda_nxt = 1'b1;
          end
          if ((phase_r == i2cm_pkg::PH_K3) && more_bytes) begin
            phase_nxt = i2cm_pkg::PH_K4;
          end else begin
            bytec_nxt = bytec_inc[LW-1:0];
            if (more_bytes) begin
              bitc_nxt = '0; shift_nxt = '0; phase_nxt = i2cm_pkg::PH_RXA;
            end else begin
              phase_nxt = i2cm_pkg::PH_SP1;
            end
          end
        end
        i2cm_pkg::PH_SP1: begin
          sda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_SP2;
        end
        i2cm_pkg::PH_SP2: begin
          scl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_SP3;
        end
        i2cm_pkg::PH_SP3: begin
          sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_FIN;
        end
        default: begin
          delay_nxt = delay_r;
          phase_nxt = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_release = sda_nxt;
    res.busy_res    = (phase_nxt != i2cm_pkg::PH_IDLE);
    res.rx_valid    = 1'b0;
    res.rx_byte     = 8'd0;
    res.done_res    = 1'b0;
    res.status      = i2cm_pkg::STATUS_OK;
    if (is_start && zero_read) begin
      res.done_res = 1'b1;
      res.status   = i2cm_pkg::STATUS_ZERO_LEN;
    end else if (tick_act && (phase_r == i2cm_pkg::PH_FIN)) begin
      res.done_res = 1'b1;
      res.status   = failed_r ? i2cm_pkg::STATUS_TIMEOUT : i2cm_pkg::STATUS_OK;
    end else if (tick_act && (phase_r == i2cm_pkg::PH_RXB) && (bitc_r >= 4'd7)) begin
      res.rx_valid = 1'b1;
      res.rx_byte  = {shift_r[6:0], sda_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r   <= i2cm_pkg::HALF_PERIOD_RST;
      ackto_r  <= i2cm_pkg::ACK_TIMEOUT_RST;
      phase_r  <= i2cm_pkg::PH_IDLE;
      stage_r  <= i2cm_pkg::STG_ADDR_W;
      delay_r  <= '0;
      ackw_r   <= '0;
      bitc_r   <= '0;
      shift_r  <= '0;
      bytec_r  <= '0;
      dev_r    <= '0;
      reg_r    <= '0;
      read_r   <= 1'b0;
      len_r    <= '0;
      failed_r <= 1'b0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
    end else begin
      if (cfg_wr && (cfg_index == i2cm_pkg::CFG_HALF_PERIOD)) begin
        half_r <= cfg_data;
      end
      if (cfg_wr && (cfg_index == i2cm_pkg::CFG_ACK_TIMEOUT)) begin
        ackto_r <= cfg_data;
      end
      phase_r  <= phase_nxt;
      stage_r  <= stage_nxt;
      delay_r  <= delay_nxt;
      ackw_r   <= ackw_nxt;
      bitc_r   <= bitc_nxt;
      shift_r  <= shift_nxt;
      bytec_r  <= bytec_nxt;
      dev_r    <= dev_nxt;
      reg_r    <= reg_nxt;
      read_r   <= read_nxt;
      len_r    <= len_nxt;
      failed_r <= failed_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
    end
  end

  `I2CM_ASSERT_NEXT(a_delay_counts_down, clk, rst_n, is_tick && (delay_r != 10'd0), delay_r == $past(delay_r) - 10'd1, "line step delay did not count down")
  `I2CM_ASSERT_NEXT(a_rx_then_ack, clk, rst_n, res.rx_valid, phase_r == i2cm_pkg::PH_K1, "received byte not followed by acknowledge")
  `I2CM_ASSERT_NEXT(a_fin_to_idle, clk, rst_n, tick_act && (phase_r == i2cm_pkg::PH_FIN), (phase_r == i2cm_pkg::PH_IDLE) && scl_r && sda_r, "transfer end left lines driven")

endmodule
